>>> rtl/psm_pkg.sv
`timescale 1ns / 1ps

package psm_pkg;

    // Default sample width and calibration reset codes
    localparam int SAMPLE_BITS_DEFAULT = 10;
    localparam int CLOSED_RESET_CODE   = 0;
    localparam int OPEN_RESET_CODE     = 1023;

    // Input item kinds
    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_SWITCH = 2'd1,
        OP_WINDOW = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    // End-switch states
    localparam logic [1:0] SW_CLEAR   = 2'd0;
    localparam logic [1:0] SW_AT_STOP = 2'd1;

    // Configuration register indexes
    localparam logic CFG_CLOSED = 1'b0;
    localparam logic CFG_OPEN   = 1'b1;

    // Health check limits
    localparam int EXCURSION_LIMIT = 16;
    localparam int RUNS_TO_STUCK   = 3;
    localparam int WINDOWS_NEEDED  = 2;

endpackage

>>> rtl/psm_if.sv
`timescale 1ns / 1ps

// Input channel: one item per handshake
interface psm_in_if #(
    parameter int SAMPLE_BITS = psm_pkg::SAMPLE_BITS_DEFAULT
);
    logic                   valid;
    logic                   ready;
    logic [1:0]             opcode;
    logic [SAMPLE_BITS-1:0] sample;
    logic [1:0]             switch_state;

    modport source (output valid, output opcode, output sample, output switch_state,
                    input ready);
    modport sink   (input valid, input opcode, input sample, input switch_state,
                    output ready);
endinterface

// Result channel: current health flags
interface psm_out_if;
    logic valid;
    logic ready;
    logic implausible;
    logic stuck;

    modport source (output valid, output implausible, output stuck, input ready);
    modport sink   (input valid, input implausible, input stuck, output ready);
endinterface

>>> rtl/psm_cfg.sv
`timescale 1ns / 1ps

module psm_cfg #(
    parameter int SAMPLE_BITS = psm_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [SAMPLE_BITS-1:0] cfg_wdata,
    output logic [SAMPLE_BITS-1:0] lo_band,
    output logic [SAMPLE_BITS:0]   hi_band
);

    localparam logic [SAMPLE_BITS-1:0] CLOSED_RESET = SAMPLE_BITS'(psm_pkg::CLOSED_RESET_CODE);
    localparam logic [SAMPLE_BITS-1:0] OPEN_RESET   = SAMPLE_BITS'(psm_pkg::OPEN_RESET_CODE);

    logic [SAMPLE_BITS-1:0] closed_reg;
    logic [SAMPLE_BITS-1:0] open_reg;
    logic [SAMPLE_BITS-1:0] lo;
    logic [SAMPLE_BITS-1:0] hi;
    logic [SAMPLE_BITS-1:0] margin;

    // Calibration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            closed_reg <= CLOSED_RESET;
            open_reg   <= OPEN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                psm_pkg::CFG_CLOSED: closed_reg <= cfg_wdata;
                psm_pkg::CFG_OPEN:   open_reg   <= cfg_wdata;
                default:             ;
            endcase
        end
    end

    // Band: calibrated span widened by a quarter on each side, low edge floored at zero
    always_comb
    begin
        lo      = (closed_reg < open_reg) ? closed_reg : open_reg;
        hi      = (closed_reg < open_reg) ? open_reg : closed_reg;
        margin  = (hi - lo) >> 2;
        lo_band = (margin >= lo) ? '0 : lo - margin;
        hi_band = {1'b0, hi} + {1'b0, margin};
    end

endmodule

>>> rtl/psm_core.sv
`timescale 1ns / 1ps

module psm_core #(
    parameter int SAMPLE_BITS = psm_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  logic [1:0]             opcode,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic [1:0]             switch_state,
    input  logic [SAMPLE_BITS-1:0] lo_band,
    input  logic [SAMPLE_BITS:0]   hi_band,
    output logic                   implausible_next,
    output logic                   stuck_next
);

    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_AT_STOP = 2'd1,
        ST_AWAY    = 2'd2
    } seq_state_t;

    localparam logic [1:0] WINDOWS_NEEDED = 2'(psm_pkg::WINDOWS_NEEDED);
    localparam logic [1:0] RUNS_TO_STUCK  = 2'(psm_pkg::RUNS_TO_STUCK);
    localparam logic [SAMPLE_BITS-1:0] EXCURSION_LIMIT =
        SAMPLE_BITS'(psm_pkg::EXCURSION_LIMIT);

    seq_state_t             state_reg, state_next;
    logic [1:0]             away_reg, away_next;
    logic [SAMPLE_BITS-1:0] low_reg, low_next;
    logic [SAMPLE_BITS-1:0] high_reg, high_next;
    logic [1:0]             run_reg, run_next;
    logic                   stuck_reg;
    logic [1:0]             outside_reg, outside_next;
    logic                   implausible_reg;
    logic [SAMPLE_BITS-1:0] wide_low;
    logic [SAMPLE_BITS-1:0] wide_high;
    logic                   outside;

    always_comb
    begin
        // Tracking window including this sample
        wide_low  = (sample < low_reg) ? sample : low_reg;
        wide_high = (sample > high_reg) ? sample : high_reg;
        outside   = (sample < lo_band) || ({1'b0, sample} > hi_band);

        state_next       = state_reg;
        away_next        = away_reg;
        low_next         = low_reg;
        high_next        = high_reg;
        run_next         = run_reg;
        stuck_next       = stuck_reg;
        outside_next     = outside_reg;
        implausible_next = implausible_reg;

        case (opcode)
            psm_pkg::OP_SAMPLE:
            begin
                if (state_reg == ST_AT_STOP || state_reg == ST_AWAY)
                begin
                    low_next  = wide_low;
                    high_next = wide_high;
                end
            end
            psm_pkg::OP_SWITCH:
            begin
                unique case (state_reg)
                    ST_AT_STOP:
                    begin
                        if (switch_state == psm_pkg::SW_CLEAR)
                        begin
                            state_next = ST_AWAY;
                            away_next  = '0;
                            low_next   = wide_low;
                            high_next  = wide_high;
                        end
                    end
                    ST_AWAY:
                    begin
                        if (switch_state == psm_pkg::SW_AT_STOP)
                        begin
                            // Sequence complete: judge it only if it stayed away long enough
                            if (away_reg >= WINDOWS_NEEDED)
                            begin
                                if (wide_high - wide_low < EXCURSION_LIMIT)
                                begin
                                    if (run_reg < RUNS_TO_STUCK)
                                        run_next = run_reg + 2'd1;
                                    if (run_next >= RUNS_TO_STUCK)
                                        stuck_next = 1'b1;
                                end
                                else
                                begin
                                    run_next   = '0;
                                    stuck_next = 1'b0;
                                end
                            end
                            state_next = ST_AT_STOP;
                            low_next   = sample;
                            high_next  = sample;
                            away_next  = '0;
                        end
                    end
                    default:
                    begin
                        if (switch_state == psm_pkg::SW_AT_STOP)
                        begin
                            state_next = ST_AT_STOP;
                            low_next   = sample;
                            high_next  = sample;
                            away_next  = '0;
                        end
                    end
                endcase
            end
            psm_pkg::OP_WINDOW:
            begin
                if (state_reg == ST_AWAY && away_reg < WINDOWS_NEEDED)
                    away_next = away_reg + 2'd1;
                // Plausibility check against the widened band
                if (outside)
                begin
                    if (outside_reg < WINDOWS_NEEDED)
                        outside_next = outside_reg + 2'd1;
                    if (outside_next >= WINDOWS_NEEDED)
                        implausible_next = 1'b1;
                end
                else
                begin
                    outside_next     = '0;
                    implausible_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // Monitor state, updated as each item is committed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            away_reg        <= '0;
            low_reg         <= '1;
            high_reg        <= '0;
            run_reg         <= '0;
            stuck_reg       <= 1'b0;
            outside_reg     <= '0;
            implausible_reg <= 1'b0;
        end
        else if (advance)
        begin
            state_reg       <= state_next;
            away_reg        <= away_next;
            low_reg         <= low_next;
            high_reg        <= high_next;
            run_reg         <= run_next;
            stuck_reg       <= stuck_next;
            outside_reg     <= outside_next;
            implausible_reg <= implausible_next;
        end
    end

endmodule

>>> rtl/position_sensor_health_monitor_top.sv
`timescale 1ns / 1ps

// Health monitor for a draw-wire position sensor. Takes one item per clock
// while results are accepted (sample note, end-switch event or window tick)
// and returns exactly one result item per input item, carrying the implausible
// and stuck flags as they stand after that item. An item passes an input
// register, then one pass of compare and saturating-counter logic writes the
// monitor state and the result register; the input register can take the next
// item while a result waits. Calibration codes are to be written through
// cfg_we/cfg_index/cfg_wdata only while the block is idle, which the block
// itself does not enforce; the plausible band follows them at once.
module position_sensor_health_monitor_top #(
    parameter int SAMPLE_BITS = psm_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [SAMPLE_BITS-1:0] cfg_wdata,
    psm_in_if.sink                 in_item,
    psm_out_if.source              out_item
);

    logic                   s1_valid_reg;
    logic [1:0]             s1_opcode_reg;
    logic [SAMPLE_BITS-1:0] s1_sample_reg;
    logic [1:0]             s1_switch_reg;
    logic                   out_valid_reg;
    logic                   out_implausible_reg;
    logic                   out_stuck_reg;
    logic                   advance;
    logic                   in_take;
    logic [SAMPLE_BITS-1:0] lo_band;
    logic [SAMPLE_BITS:0]   hi_band;
    logic                   implausible_next;
    logic                   stuck_next;

    psm_cfg #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .lo_band   (lo_band),
        .hi_band   (hi_band)
    );

    psm_core #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .advance          (advance),
        .opcode           (s1_opcode_reg),
        .sample           (s1_sample_reg),
        .switch_state     (s1_switch_reg),
        .lo_band          (lo_band),
        .hi_band          (hi_band),
        .implausible_next (implausible_next),
        .stuck_next       (stuck_next)
    );

    // Handshake: commit when the result slot is free or being emptied
    assign advance       = s1_valid_reg && (!out_valid_reg || out_item.ready);
    assign in_item.ready = !s1_valid_reg || advance;
    assign in_take       = in_item.valid && in_item.ready;

    assign out_item.valid       = out_valid_reg;
    assign out_item.implausible = out_implausible_reg;
    assign out_item.stuck       = out_stuck_reg;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_item.ready)
            s1_valid_reg <= in_item.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_opcode_reg <= in_item.opcode;
            s1_sample_reg <= in_item.sample;
            s1_switch_reg <= in_item.switch_state;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_item.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_implausible_reg <= implausible_next;
            out_stuck_reg       <= stuck_next;
        end
    end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int SB            = psm_pkg::SAMPLE_BITS_DEFAULT;
    localparam int MAX_CODE      = (1 << SB) - 1;
    localparam int LONG_HOLD     = 300;
    localparam int DRAIN_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 3000;

    // Departure sequence tracking states
    typedef enum logic [1:0] {
        MON_IDLE    = 2'd0,
        MON_AT_STOP = 2'd1,
        MON_AWAY    = 2'd2
    } seq_state_t;

    // Result item fields
    typedef struct packed {
        logic implausible;
        logic stuck;
    } health_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    logic [SB-1:0] cfg_wdata;

    psm_in_if #(.SAMPLE_BITS(SB)) in_ch ();
    psm_out_if out_ch ();

    position_sensor_health_monitor_top #(
        .SAMPLE_BITS(SB)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_item   (in_ch),
        .out_item  (out_ch)
    );

    // Health model state and calibration
    seq_state_t    seq_state;
    logic [1:0]    away_wins;
    logic [SB-1:0] trk_lo;
    logic [SB-1:0] trk_hi;
    logic [1:0]    low_runs;
    logic          stuck_q;
    logic [1:0]    outside_windows;
    logic          implaus_q;
    logic [SB-1:0] cal_closed;
    logic [SB-1:0] cal_open;

    health_t flags_due[$];

    int  mismatches;
    int  items_sent;
    int  results_checked;
    int  stuck_rises;
    int  implaus_rises;
    int  quiet_cycles;
    int  hold_left;
    int  stall_left;
    bit  hold_req;
    bit  src_idle_en;
    bit  snk_idle_en;

    // Clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // ------------------------------------------------------------------
    // Health model
    // ------------------------------------------------------------------
    function automatic void widen_track(logic [SB-1:0] s);
        if (s < trk_lo)
            trk_lo = s;
        if (s > trk_hi)
            trk_hi = s;
    endfunction

    function automatic void start_at_stop(logic [SB-1:0] s);
        seq_state = MON_AT_STOP;
        trk_lo    = s;
        trk_hi    = s;
        away_wins = '0;
    endfunction

    function automatic void apply_switch(logic [1:0] sw, logic [SB-1:0] s);
        case (seq_state)
            MON_AT_STOP:
            begin
                if (sw == psm_pkg::SW_CLEAR)
                begin
                    seq_state = MON_AWAY;
                    away_wins = '0;
                    widen_track(s);
                end
            end
            MON_AWAY:
            begin
                if (sw == psm_pkg::SW_AT_STOP)
                begin
                    widen_track(s);
                    // only departures long enough to judge move the run count
                    if (away_wins >= psm_pkg::WINDOWS_NEEDED)
                    begin
                        if (int'(trk_hi) - int'(trk_lo) < psm_pkg::EXCURSION_LIMIT)
                        begin
                            if (low_runs < psm_pkg::RUNS_TO_STUCK)
                                low_runs++;
                            if (low_runs >= psm_pkg::RUNS_TO_STUCK)
                            begin
                                if (!stuck_q)
                                    stuck_rises++;
                                stuck_q = 1'b1;
                            end
                        end
                        else
                        begin
                            low_runs = '0;
                            stuck_q  = 1'b0;
                        end
                    end
                    start_at_stop(s);
                end
            end
            default:
            begin
                if (sw == psm_pkg::SW_AT_STOP)
                    start_at_stop(s);
            end
        endcase
    endfunction

    function automatic void apply_window(logic [SB-1:0] s);
        int lo_cal;
        int hi_cal;
        int margin;
        int lo_band;
        int hi_band;

        if (seq_state == MON_AWAY && away_wins < psm_pkg::WINDOWS_NEEDED)
            away_wins++;

        // band widened by a quarter of the span, low edge clamped at zero
        lo_cal  = (cal_closed < cal_open) ? int'(cal_closed) : int'(cal_open);
        hi_cal  = (cal_closed < cal_open) ? int'(cal_open) : int'(cal_closed);
        margin  = (hi_cal - lo_cal) / 4;
        lo_band = (margin >= lo_cal) ? 0 : lo_cal - margin;
        hi_band = hi_cal + margin;

        if (int'(s) < lo_band || int'(s) > hi_band)
        begin
            if (outside_windows < psm_pkg::WINDOWS_NEEDED)
                outside_windows++;
            if (outside_windows >= psm_pkg::WINDOWS_NEEDED)
            begin
                if (!implaus_q)
                    implaus_rises++;
                implaus_q = 1'b1;
            end
        end
        else
        begin
            outside_windows = '0;
            implaus_q       = 1'b0;
        end
    endfunction

    function automatic health_t step_monitor(psm_pkg::opcode_t op, logic [SB-1:0] s,
                                             logic [1:0] sw);
        health_t h;

        case (op)
            psm_pkg::OP_SAMPLE:
            begin
                if (seq_state == MON_AT_STOP || seq_state == MON_AWAY)
                    widen_track(s);
            end
            psm_pkg::OP_SWITCH: apply_switch(sw, s);
            psm_pkg::OP_WINDOW: apply_window(s);
            default: ;
        endcase
        h.implausible = implaus_q;
        h.stuck       = stuck_q;
        return h;
    endfunction

    function automatic void reset_monitor();
        cal_closed      = SB'(psm_pkg::CLOSED_RESET_CODE);
        cal_open        = SB'(psm_pkg::OPEN_RESET_CODE);
        seq_state       = MON_IDLE;
        away_wins       = '0;
        trk_lo          = '1;
        trk_hi          = '0;
        low_runs        = '0;
        stuck_q         = 1'b0;
        outside_windows = '0;
        implaus_q       = 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers (called at the falling edge)
    // ------------------------------------------------------------------
    task automatic send_item(psm_pkg::opcode_t op, logic [SB-1:0] s, logic [1:0] sw);
        if (src_idle_en && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        in_ch.valid        = 1'b1;
        in_ch.opcode       = op;
        in_ch.sample       = s;
        in_ch.switch_state = sw;
        do
            @(posedge clk);
        while (!in_ch.ready);
        flags_due.push_back(step_monitor(op, s, sw));
        items_sent++;
        @(negedge clk);
    endtask

    task automatic settle_idle();
        in_ch.valid = 1'b0;
        while (flags_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_calibration(logic idx, logic [SB-1:0] code);
        settle_idle();
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = code;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == psm_pkg::CFG_CLOSED)
            cal_closed = code;
        else
            cal_open = code;
    endtask

    function automatic logic [SB-1:0] near_base(int base, int span);
        int v;

        v = base + $urandom_range(0, span);
        if (v > MAX_CODE)
            v = MAX_CODE;
        return v[SB-1:0];
    endfunction

    task automatic send_noise();
        send_item(psm_pkg::opcode_t'($urandom_range(0, 3)), SB'($urandom_range(0, MAX_CODE)),
                  2'($urandom_range(0, 3)));
    endtask

    // One departure: stop, away for some windows with notes, back at stop
    task automatic run_sequence();
        int base;
        int span;
        int nwin;
        logic [SB-1:0] win_s;

        base = $urandom_range(0, MAX_CODE);
        span = ($urandom_range(0, 99) < 65)
               ? $urandom_range(0, psm_pkg::EXCURSION_LIMIT - 1)
               : $urandom_range(0, MAX_CODE);
        nwin = $urandom_range(0, 3);
        send_item(psm_pkg::OP_SWITCH, near_base(base, span), psm_pkg::SW_AT_STOP);
        send_item(psm_pkg::OP_SWITCH, near_base(base, span), psm_pkg::SW_CLEAR);
        repeat (nwin)
        begin
            repeat ($urandom_range(0, 2))
                send_item(psm_pkg::OP_SAMPLE, near_base(base, span),
                          2'($urandom_range(0, 3)));
            win_s = $urandom_range(0, 1) ? SB'($urandom_range(0, MAX_CODE))
                                         : near_base(base, span);
            send_item(psm_pkg::OP_WINDOW, win_s, 2'($urandom_range(0, 3)));
            if ($urandom_range(0, 7) == 0)
                send_noise();
        end
        send_item(psm_pkg::OP_SWITCH, near_base(base, span), psm_pkg::SW_AT_STOP);
    endtask

    task automatic pick_calibration();
        logic [SB-1:0] c;

        case ($urandom_range(0, 5))
            0:
            begin
                write_calibration(psm_pkg::CFG_CLOSED, '0);
                write_calibration(psm_pkg::CFG_OPEN, SB'(MAX_CODE));
            end
            1:
            begin
                write_calibration(psm_pkg::CFG_CLOSED, SB'(MAX_CODE));
                write_calibration(psm_pkg::CFG_OPEN, '0);
            end
            2:
            begin
                write_calibration(psm_pkg::CFG_CLOSED, '0);
                write_calibration(psm_pkg::CFG_OPEN, '0);
            end
            3:
            begin
                write_calibration(psm_pkg::CFG_CLOSED, SB'(MAX_CODE));
                write_calibration(psm_pkg::CFG_OPEN, SB'(MAX_CODE));
            end
            4:
            begin
                write_calibration(psm_pkg::CFG_CLOSED, SB'($urandom_range(0, MAX_CODE)));
                write_calibration(psm_pkg::CFG_OPEN, SB'($urandom_range(0, MAX_CODE)));
            end
            default:
            begin
                c = SB'($urandom_range(0, MAX_CODE - 40));
                write_calibration(psm_pkg::CFG_CLOSED, SB'(c + $urandom_range(0, 40)));
                write_calibration(psm_pkg::CFG_OPEN, c);
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Items that must leave the state alone while idle
    task automatic test_idle_cases();
        send_item(psm_pkg::OP_NONE, SB'(MAX_CODE), 2'd3);
        send_item(psm_pkg::OP_SAMPLE, '0, psm_pkg::SW_AT_STOP);
        send_item(psm_pkg::OP_SWITCH, SB'(MAX_CODE), 2'd2);
        send_item(psm_pkg::OP_SWITCH, '0, 2'd3);
        send_item(psm_pkg::OP_SWITCH, 10'd5, psm_pkg::SW_CLEAR);
        send_item(psm_pkg::OP_WINDOW, '0, psm_pkg::SW_CLEAR);
        send_item(psm_pkg::OP_WINDOW, SB'(MAX_CODE), psm_pkg::SW_CLEAR);
    endtask

    // Three low-excursion departures, a short one, then a good one
    task automatic test_stuck_sequences();
        send_item(psm_pkg::OP_SWITCH, 10'd500, psm_pkg::SW_AT_STOP);
        repeat (3)
        begin
            send_item(psm_pkg::OP_SWITCH, 10'd505, psm_pkg::SW_CLEAR);
            send_item(psm_pkg::OP_WINDOW, 10'd503, psm_pkg::SW_CLEAR);
            send_item(psm_pkg::OP_WINDOW, 10'd507, psm_pkg::SW_CLEAR);
            send_item(psm_pkg::OP_SWITCH, 10'd510, psm_pkg::SW_AT_STOP);
        end
        // short departure keeps the flag
        send_item(psm_pkg::OP_SWITCH, 10'd900, psm_pkg::SW_CLEAR);
        send_item(psm_pkg::OP_WINDOW, 10'd900, psm_pkg::SW_CLEAR);
        send_item(psm_pkg::OP_SWITCH, 10'd505, psm_pkg::SW_AT_STOP);
        // wide excursion clears it
        send_item(psm_pkg::OP_SWITCH, 10'd505, psm_pkg::SW_CLEAR);
        send_item(psm_pkg::OP_SAMPLE, 10'd900, psm_pkg::SW_CLEAR);
        send_item(psm_pkg::OP_WINDOW, 10'd505, psm_pkg::SW_CLEAR);
        send_item(psm_pkg::OP_WINDOW, 10'd505, psm_pkg::SW_CLEAR);
        send_item(psm_pkg::OP_SWITCH, 10'd505, psm_pkg::SW_AT_STOP);
    endtask

    // Band edges with reversed calibration and with a clamped low edge
    task automatic test_band_check();
        write_calibration(psm_pkg::CFG_CLOSED, 10'd600);
        write_calibration(psm_pkg::CFG_OPEN, 10'd200);
        send_item(psm_pkg::OP_WINDOW, 10'd99, psm_pkg::SW_CLEAR);
        send_item(psm_pkg::OP_WINDOW, 10'd99, psm_pkg::SW_CLEAR);
        send_item(psm_pkg::OP_WINDOW, 10'd700, psm_pkg::SW_CLEAR);
        send_item(psm_pkg::OP_WINDOW, 10'd701, psm_pkg::SW_CLEAR);
        send_item(psm_pkg::OP_WINDOW, 10'd701, psm_pkg::SW_CLEAR);
        send_item(psm_pkg::OP_WINDOW, 10'd100, psm_pkg::SW_CLEAR);
        write_calibration(psm_pkg::CFG_CLOSED, 10'd3);
        write_calibration(psm_pkg::CFG_OPEN, 10'd20);
        send_item(psm_pkg::OP_WINDOW, 10'd25, psm_pkg::SW_CLEAR);
        send_item(psm_pkg::OP_WINDOW, 10'd25, psm_pkg::SW_CLEAR);
        send_item(psm_pkg::OP_WINDOW, '0, psm_pkg::SW_CLEAR);
    endtask

    // Random departures and noise over several calibrations
    task automatic test_random(int target);
        int phase_end;

        while (items_sent < target)
        begin
            pick_calibration();
            src_idle_en = $urandom_range(0, 3) != 0;
            snk_idle_en = $urandom_range(0, 3) != 0;
            phase_end   = items_sent + 40;
            while (items_sent < phase_end)
            begin
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 3)) send_noise();
                else
                    run_sequence();
            end
        end
    endtask

    // Receiver holds off long enough for the block to back up
    task automatic test_backpressure();
        int stop_at;

        settle_idle();
        src_idle_en = 1'b0;
        hold_req    = 1'b1;
        stop_at     = items_sent + 40;
        while (items_sent < stop_at)
            run_sequence();
    endtask

    // Full rate on both sides to finish
    task automatic test_steady();
        int stop_at;

        pick_calibration();
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        stop_at     = items_sent + 60;
        while (items_sent < stop_at)
            run_sequence();
        in_ch.valid = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = psm_pkg::CFG_CLOSED;
        cfg_wdata          = '0;
        in_ch.valid        = 1'b0;
        in_ch.opcode       = psm_pkg::OP_SAMPLE;
        in_ch.sample       = '0;
        in_ch.switch_state = psm_pkg::SW_CLEAR;
        out_ch.ready       = 1'b0;
        mismatches         = 0;
        items_sent         = 0;
        results_checked    = 0;
        stuck_rises        = 0;
        implaus_rises      = 0;
        hold_req           = 1'b0;
        src_idle_en        = 1'b1;
        snk_idle_en        = 1'b1;
        reset_monitor();
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_idle_cases();
        test_stuck_sequences();
        test_band_check();
        test_random(300);
        test_backpressure();
        test_steady();

        while (flags_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        $display("Covered %0d items / %0d results over idle, stuck, band and random cases",
                 items_sent, results_checked);
        $display("Stuck flag rose %0d times, implausible flag rose %0d times; %0d mismatches",
                 stuck_rises, implaus_rises, mismatches);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls plus one long hold on request
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ch.ready = 1'b0;
        else
        begin
            if (hold_req)
            begin
                hold_left = LONG_HOLD;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready = 1'b0;
            end
            else if (snk_idle_en && $urandom_range(0, 5) == 0)
            begin
                stall_left   = $urandom_range(0, 9);
                out_ch.ready = 1'b0;
            end
            else
                out_ch.ready = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, logic got, logic want);
        $display("ERROR @%0t: %s got %0b want %0b", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        health_t want;

        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (flags_due.size() == 0)
                report_mismatch("result with nothing pending, stuck", out_ch.stuck, 1'b0);
            else
            begin
                want = flags_due.pop_front();
                results_checked++;
                if (out_ch.implausible !== want.implausible)
                    report_mismatch("implausible", out_ch.implausible, want.implausible);
                if (out_ch.stuck !== want.stuck)
                    report_mismatch("stuck", out_ch.stuck, want.stuck);
            end
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no item moved for %0d cycles", quiet_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        quiet_cycles = 0;
        hold_left    = 0;
        stall_left   = 0;
    end

endmodule
